FILE: sv/fsc_pkg.sv
package fsc_pkg;

   localparam int FLAME_W  = 3;
   localparam int GROWTH_W = 17;
   localparam int ODDS_W   = 33;
   localparam int DRAW_W   = 32;
   localparam int STEP_W   = 8;
   localparam int GAIN_W   = 16;
   localparam int RATE_W   = 32;
   localparam int HEAT_W   = 6;
   localparam int NCNT_W   = 4;
   localparam int PROD1_W  = HEAT_W + GROWTH_W;
   localparam int PROD2_W  = PROD1_W + GAIN_W;
   localparam int ZPROD_W  = GROWTH_W + RATE_W;
   localparam int DIVS_W   = NCNT_W + 2;
   localparam int COORD_W  = 11;
   localparam int SCAN_N   = 9;
   localparam int SCAN_W   = 4;

   localparam logic [FLAME_W-1:0]  FLAME_FULL = 3'd4;
   localparam logic [GROWTH_W-1:0] GROWTH_ONE = 17'd65536;
   localparam logic [GROWTH_W-1:0] GROWTH_MAX = 17'h1FFFF;
   localparam logic [ODDS_W-1:0]   ODDS_ONE   = 33'h1_0000_0000;
   localparam logic [ODDS_W-1:0]   ODDS_MAX   = 33'h1_FFFF_FFFF;
   localparam logic [GAIN_W-1:0]   GAIN_RESET = 16'd52429;
   localparam logic [RATE_W-1:0]   RATE_RESET = 32'd42950;
   localparam logic [SCAN_W-1:0]   SCAN_SELF  = 4'd4;
   localparam logic [SCAN_W-1:0]   SCAN_LAST  = 4'd8;

   localparam logic ACT_LOAD   = 1'b0;
   localparam logic ACT_UPDATE = 1'b1;

   localparam logic CSR_SPREAD_GAIN = 1'b0;
   localparam logic CSR_IGNITE_RATE = 1'b1;

   // Offsets are stored plus one, so 0 means one row or column back.
   localparam logic [1:0] ROW_OFS [SCAN_N] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1,
                                               2'd2, 2'd2, 2'd2};
   localparam logic [1:0] COL_OFS [SCAN_N] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2,
                                               2'd0, 2'd1, 2'd2};

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_MUL1,
      ST_MUL2,
      ST_SEL,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage

FILE: sv/fire_spread_cell_update.sv
// Load beat: result strobe in the cycle after acceptance; busy stays low.
// Update beat: SCAN sends the nine flame reads through the single read port; then DRAIN, MUL1,
// MUL2, SEL, the 39-step divider only if any neighbor burns, and DONE registers the strobe.
// One item at a time; start is taken again once busy falls. Results cannot be stalled.
// Reset: synchronous; the flame memory is then cleared, one cell per cycle,
// all GRID_ROWS * GRID_COLS cells with busy high; configuration writes are taken meanwhile.
module fire_spread_cell_update
   import fsc_pkg::*;
#(
   parameter int GRID_ROWS = 128,
   parameter int GRID_COLS = 128
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_action,
   input  logic [6:0]          req_row_index,
   input  logic [6:0]          req_col_index,
   input  logic [GROWTH_W-1:0] req_load_growth,
   input  logic [DRAW_W-1:0]   req_catch_draw,
   input  logic [STEP_W-1:0]   req_growth_step,
   output logic                rsp_strobe,
   output logic [FLAME_W-1:0]  rsp_flame_level,
   output logic [GROWTH_W-1:0] rsp_growth_out,
   output logic                rsp_ignited,
   output logic [ODDS_W-1:0]   rsp_odds_out,
   input  logic                csr_wr_en,
   input  logic                csr_index,
   input  logic [RATE_W-1:0]   csr_wdata
);

   localparam int CELLS  = GRID_ROWS * GRID_COLS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam logic [COORD_W-1:0] ROWS_L = COORD_W'(GRID_ROWS);
   localparam logic [COORD_W-1:0] COLS_L = COORD_W'(GRID_COLS);
   localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(CELLS - 1);

   state_type state_ff, state_in;

   logic [ADDR_W-1:0]   clr_ff;
   logic [SCAN_W-1:0]   k_ff;
   logic [COORD_W-1:0]  row_ff, col_ff;
   logic [ADDR_W-1:0]   self_addr_ff;
   logic [DRAW_W-1:0]   draw_ff;
   logic [STEP_W-1:0]   step_ff;
   logic [HEAT_W-1:0]   heat_ff;
   logic [NCNT_W-1:0]   count_ff;
   logic                nb_valid_ff, self_valid_ff;
   logic [FLAME_W-1:0]  self_flame_ff;
   logic [GROWTH_W-1:0] growth_ff;
   logic [PROD1_W-1:0]  prod1_ff;
   logic [PROD2_W-1:0]  prod2_ff;
   logic [ZPROD_W-1:0]  zprod_ff;
   logic [ODDS_W-1:0]   odds_ff;
   logic [GAIN_W-1:0]   gain_ff;
   logic [RATE_W-1:0]   rate_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [FLAME_W-1:0]  rsp_flame_ff, rsp_flame_in;
   logic [GROWTH_W-1:0] rsp_growth_ff, rsp_growth_in;
   logic                rsp_ignited_ff, rsp_ignited_in;
   logic [ODDS_W-1:0]   rsp_odds_ff, rsp_odds_in;

   logic                accept;
   logic [COORD_W-1:0]  in_row, in_col;
   logic                in_range;
   logic [ADDR_W-1:0]   in_addr;
   logic [COORD_W-1:0]  nb_row, nb_col;
   logic                nb_in;
   logic [ADDR_W-1:0]   nb_addr;

   logic                flame_we, flame_re;
   logic [ADDR_W-1:0]   flame_waddr;
   logic [FLAME_W-1:0]  flame_wdata, flame_rdata;
   logic                growth_we, growth_re;
   logic [ADDR_W-1:0]   growth_waddr, growth_raddr;
   logic [GROWTH_W-1:0] growth_wdata, growth_rdata;

   logic                div_start, div_done;
   logic [PROD2_W-1:0]  div_quo;
   logic [ODDS_W-1:0]   div_odds;

   logic                catches;
   logic                grow_ok;
   logic [GROWTH_W:0]   grow_sum;
   logic [FLAME_W-1:0]  new_flame;
   logic [GROWTH_W-1:0] new_growth;

   assign accept   = start && !busy;
   assign busy     = (state_ff != ST_IDLE);
   assign in_row   = COORD_W'(req_row_index);
   assign in_col   = COORD_W'(req_col_index);
   assign in_range = (in_row < ROWS_L) && (in_col < COLS_L);
   assign in_addr  = ADDR_W'(in_row * GRID_COLS + in_col);

   // A neighbor one step back below row 0 wraps to all ones and fails the bound check.
   assign nb_row  = row_ff + COORD_W'(ROW_OFS[k_ff]) - COORD_W'(1);
   assign nb_col  = col_ff + COORD_W'(COL_OFS[k_ff]) - COORD_W'(1);
   assign nb_in   = (nb_row < ROWS_L) && (nb_col < COLS_L);
   assign nb_addr = ADDR_W'(nb_row * GRID_COLS + nb_col);

   assign div_odds = (|div_quo[PROD2_W-1:ODDS_W]) ? ODDS_MAX : div_quo[ODDS_W-1:0];

   fsc_ram #(.WIDTH(FLAME_W), .DEPTH(CELLS)) u_flame_ram (
      .clock   (clock),
      .wr_en   (flame_we),
      .wr_addr (flame_waddr),
      .wr_data (flame_wdata),
      .rd_en   (flame_re),
      .rd_addr (nb_addr),
      .rd_data (flame_rdata)
   );

   fsc_ram #(.WIDTH(GROWTH_W), .DEPTH(CELLS)) u_growth_ram (
      .clock   (clock),
      .wr_en   (growth_we),
      .wr_addr (growth_waddr),
      .wr_data (growth_wdata),
      .rd_en   (growth_re),
      .rd_addr (growth_raddr),
      .rd_data (growth_rdata)
   );

   fsc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod2_ff),
      .divisor  ({count_ff, 2'b00}),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Ignition decision and cell update for the final state.
   always_comb begin
      catches  = (self_flame_ff == '0) &&
                 (((odds_ff < ODDS_ONE) && ({1'b0, draw_ff} <= odds_ff)) ||
                  (odds_ff > ODDS_ONE));
      grow_ok  = (growth_ff <= GROWTH_ONE);
      grow_sum = {1'b0, growth_ff} + (GROWTH_W + 1)'(step_ff);
      new_flame  = self_flame_ff;
      new_growth = growth_ff;
      if (catches) begin
         new_flame  = FLAME_FULL;
         new_growth = '0;
      end else if (self_flame_ff == '0 && grow_ok) begin
         new_growth = grow_sum[GROWTH_W] ? GROWTH_MAX : grow_sum[GROWTH_W-1:0];
      end else if (self_flame_ff != '0 && grow_ok) begin
         new_flame = self_flame_ff - 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_ff == LAST_ADDR) state_in = ST_IDLE;
         ST_IDLE: begin
            if (accept && in_range && req_action == ACT_UPDATE) state_in = ST_SCAN;
         end
         ST_SCAN:  if (k_ff == SCAN_LAST) state_in = ST_DRAIN;
         ST_DRAIN: state_in = ST_MUL1;
         ST_MUL1:  state_in = ST_MUL2;
         ST_MUL2:  state_in = ST_SEL;
         ST_SEL:   state_in = (heat_ff == '0) ? ST_DONE : ST_DIV;
         ST_DIV:   if (div_done) state_in = ST_DONE;
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      flame_we      = 1'b0;
      flame_waddr   = self_addr_ff;
      flame_wdata   = '0;
      flame_re      = 1'b0;
      growth_we     = 1'b0;
      growth_waddr  = self_addr_ff;
      growth_wdata  = new_growth;
      growth_re     = 1'b0;
      growth_raddr  = in_addr;
      div_start     = 1'b0;
      rsp_valid_in  = 1'b0;
      rsp_flame_in  = '0;
      rsp_growth_in = '0;
      rsp_ignited_in = 1'b0;
      rsp_odds_in   = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            flame_we    = 1'b1;
            flame_waddr = clr_ff;
         end
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               if (in_range && req_action == ACT_LOAD) begin
                  flame_we      = 1'b1;
                  flame_waddr   = in_addr;
                  growth_we     = 1'b1;
                  growth_waddr  = in_addr;
                  growth_wdata  = req_load_growth;
                  rsp_growth_in = req_load_growth;
               end else if (in_range) begin
                  rsp_valid_in = 1'b0;
                  growth_re    = 1'b1;
               end
            end
         end
         ST_SCAN:  flame_re = 1'b1;
         ST_SEL:   div_start = (heat_ff != '0);
         ST_DONE: begin
            flame_we       = 1'b1;
            flame_wdata    = new_flame;
            growth_we      = 1'b1;
            rsp_valid_in   = 1'b1;
            rsp_flame_in   = new_flame;
            rsp_growth_in  = new_growth;
            rsp_ignited_in = catches;
            rsp_odds_in    = odds_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         gain_ff      <= GAIN_RESET;
         rate_ff      <= RATE_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_SPREAD_GAIN: gain_ff <= csr_wdata[GAIN_W-1:0];
               CSR_IGNITE_RATE: rate_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end

      rsp_flame_ff   <= rsp_flame_in;
      rsp_growth_ff  <= rsp_growth_in;
      rsp_ignited_ff <= rsp_ignited_in;
      rsp_odds_ff    <= rsp_odds_in;

      if (accept) begin
         row_ff        <= in_row;
         col_ff        <= in_col;
         self_addr_ff  <= in_addr;
         draw_ff       <= req_catch_draw;
         step_ff       <= req_growth_step;
         k_ff          <= '0;
         heat_ff       <= '0;
         count_ff      <= '0;
         nb_valid_ff   <= 1'b0;
         self_valid_ff <= 1'b0;
      end

      // Read data is registered in the RAM and lands in the cycle after its address, so the tally trails the scan.
      if (state_ff == ST_SCAN || state_ff == ST_DRAIN) begin
         if (nb_valid_ff) begin
            heat_ff <= heat_ff + HEAT_W'(flame_rdata);
         end
         if (self_valid_ff) begin
            self_flame_ff <= flame_rdata;
         end
      end
      if (state_ff == ST_SCAN) begin
         k_ff          <= k_ff + 1'b1;
         nb_valid_ff   <= nb_in && (k_ff != SCAN_SELF);
         self_valid_ff <= (k_ff == SCAN_SELF);
         if (nb_in && k_ff != SCAN_SELF) begin
            count_ff <= count_ff + 1'b1;
         end
      end
      if (state_ff == ST_DRAIN) begin
         growth_ff <= growth_rdata;
      end
      if (state_ff == ST_MUL1) begin
         prod1_ff <= heat_ff * growth_ff;
         zprod_ff <= growth_ff * rate_ff;
      end
      if (state_ff == ST_MUL2) begin
         prod2_ff <= prod1_ff * gain_ff;
      end
      if (state_ff == ST_SEL && heat_ff == '0) begin
         odds_ff <= zprod_ff[ZPROD_W-1:GAIN_W];
      end
      if (state_ff == ST_DIV && div_done) begin
         odds_ff <= div_odds;
      end
   end

   assign rsp_strobe      = rsp_valid_ff;
   assign rsp_flame_level = rsp_flame_ff;
   assign rsp_growth_out  = rsp_growth_ff;
   assign rsp_ignited     = rsp_ignited_ff;
   assign rsp_odds_out    = rsp_odds_ff;

   a_strobe_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == ST_DONE || (state_ff == ST_IDLE && start)))
      else $error("result strobe without a finished item");

   a_flame_range: assert property (@(posedge clock) disable iff (reset)
      flame_we |-> flame_wdata <= FLAME_FULL)
      else $error("flame write above full intensity");

   a_ignite_result: assert property (@(posedge clock) disable iff (reset)
      rsp_ignited |-> (rsp_flame_level == FLAME_FULL && rsp_growth_out == '0))
      else $error("ignited cell does not show full flame and zero growth");

   a_div_only_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide state");

endmodule

FILE: sv/fsc_ram.sv
module fsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/fsc_div.sv
module fsc_div
   import fsc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [PROD2_W-1:0] dividend,
   input  logic [DIVS_W-1:0]  divisor,
   output logic               done,
   output logic [PROD2_W-1:0] quotient
);

   localparam int CNT_W = $clog2(PROD2_W + 1);

   logic [PROD2_W-1:0] quo_ff, quo_in;
   logic [DIVS_W-1:0]  rem_ff, rem_in;
   logic [DIVS_W-1:0]  dvs_ff;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               run_ff, run_in;
   logic               done_ff, done_in;
   logic [DIVS_W:0]    shifted;
   logic [DIVS_W:0]    diff;

   // One quotient bit per cycle, restoring form.
   always_comb begin
      shifted = {rem_ff, quo_ff[PROD2_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         cnt_in = CNT_W'(PROD2_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!diff[DIVS_W]) begin
            rem_in = diff[DIVS_W-1:0];
            quo_in = {quo_ff[PROD2_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIVS_W-1:0];
            quo_in = {quo_ff[PROD2_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         dvs_ff <= divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
